### rtl/core/hns_pkg.sv
package hns_pkg;

    localparam int NODES     = 16;
    localparam int IDX_W     = $clog2(NODES);
    localparam int CNT_W     = $clog2(NODES + 1);
    localparam int ID_W      = 16;
    localparam int LOAD_W    = 11;
    localparam int QLEN_W    = 16;
    localparam int RT_W      = 32;
    localparam int HCNT_W    = 7;
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [1:0] OP_METRICS = 2'd0;
    localparam logic [1:0] OP_REPORT  = 2'd1;
    localparam logic [1:0] OP_SELECT  = 2'd2;

    localparam logic [2:0] MODE_LOAD  = 3'd1;
    localparam logic [2:0] MODE_LAT   = 3'd2;
    localparam logic [2:0] MODE_ADAPT = 3'd3;

    localparam logic [2:0] CFG_DEFAULT_MODE  = 3'd3;
    localparam logic [7:0] CFG_FAIL_LIMIT    = 8'd3;
    localparam logic [7:0] CFG_RECOVER_LIMIT = 8'd5;

    localparam logic [1:0] REG_DEFAULT_MODE  = 2'd0;
    localparam logic [1:0] REG_FAIL_LIMIT    = 2'd1;
    localparam logic [1:0] REG_RECOVER_LIMIT = 2'd2;

    localparam logic [15:0] AVAIL_ONE   = 16'hFFFF;
    localparam logic [15:0] AVAIL_MUL   = 16'd62259;
    localparam logic [31:0] AVAIL_ROUND = 32'd32768;
    localparam logic [16:0] AVAIL_BONUS = 17'd3277;
    localparam logic [63:0] LAT_NUM     = 64'd65536000000;
    localparam logic [63:0] LAT_BIAS    = 64'd1000000;
    localparam logic [16:0] LAT_NONE    = 17'd65536;
    localparam logic [16:0] LOAD_ONE    = 17'd65536;
    localparam logic [10:0] LOAD_FULL   = 11'd1024;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_METRICS = 2'd1,
        KIND_REPORT  = 2'd2,
        KIND_SELECT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MTH_RR    = 2'd0,
        MTH_LOAD  = 2'd1,
        MTH_LAT   = 2'd2,
        MTH_ADAPT = 2'd3
    } method_t;

    typedef struct packed {
        kind_t              kind;
        method_t            method;
        logic [ID_W-1:0]    node;
        logic               success;
        logic [RT_W-1:0]    rtime;
        logic [LOAD_W-1:0]  cpu;
        logic [LOAD_W-1:0]  mem;
        logic [LOAD_W-1:0]  net;
        logic [QLEN_W-1:0]  qlen;
    } cmd_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [LOAD_W-1:0] clamp_load(input logic [LOAD_W-1:0] v);
        return (v > LOAD_FULL) ? LOAD_FULL : v;
    endfunction

    // floor(v / 3) for v up to 3 * 2^16: reciprocal estimate, then one correction
    function automatic logic [16:0] div3(input logic [17:0] v);
        logic [33:0] p;
        logic [16:0] q;
        logic [18:0] r;
        p = 34'(v) * 34'd21845;
        q = p[32:16];
        r = 19'(v) - 19'(q) * 19'd3;
        if (r >= 19'd3) begin
            q = q + 17'd1;
        end
        return q;
    endfunction

endpackage

### rtl/core/hns_front.sv
module hns_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic [15:0]              s_node,
    input  logic                     s_success,
    input  logic [31:0]              s_response_time,
    input  logic [10:0]              s_cpu_load,
    input  logic [10:0]              s_mem_load,
    input  logic [10:0]              s_net_load,
    input  logic [15:0]              s_queue_len,
    input  logic signed [3:0]        s_mode,
    input  logic [2:0]               default_mode,
    input  logic                     q_full,
    output logic                     q_push,
    output hns_pkg::cmd_t            q_cmd
);
    import hns_pkg::*;

    logic       fr_valid_reg;
    cmd_t       fr_cmd_reg;
    cmd_t       cls;
    logic [2:0] mbits;

    // classify: resolve the method and clamp the load figures up front
    always_comb begin
        mbits = s_mode[3] ? default_mode : 3'(s_mode[2:0]);
        cls.node    = s_node;
        cls.success = s_success;
        cls.rtime   = s_response_time;
        cls.cpu     = clamp_load(s_cpu_load);
        cls.mem     = clamp_load(s_mem_load);
        cls.net     = clamp_load(s_net_load);
        cls.qlen    = s_queue_len;
        case (mbits)
            MODE_LOAD:  cls.method = MTH_LOAD;
            MODE_LAT:   cls.method = MTH_LAT;
            MODE_ADAPT: cls.method = MTH_ADAPT;
            default:    cls.method = MTH_RR;
        endcase
        case (s_op)
            OP_METRICS: cls.kind = (s_node != '0) ? KIND_METRICS : KIND_NONE;
            OP_REPORT:  cls.kind = (s_node != '0) ? KIND_REPORT : KIND_NONE;
            OP_SELECT:  cls.kind = KIND_SELECT;
            default:    cls.kind = KIND_NONE;
        endcase
    end

    assign s_ready = !fr_valid_reg || !q_full;
    assign q_push  = fr_valid_reg && !q_full;
    assign q_cmd   = fr_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            fr_valid_reg <= 1'b1;
            fr_cmd_reg   <= cls;
        end else if (q_push) begin
            fr_valid_reg <= 1'b0;
        end
    end

endmodule

### rtl/core/hns_fifo.sv
module hns_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hns_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output hns_pkg::cmd_t cmd_out
);
    import hns_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign valid   = (cnt_reg != '0);
    assign cmd_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### rtl/core/hns_div.sv
module hns_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  hns_pkg::div_req_t req,
    output hns_pkg::div_rsp_t rsp
);
    import hns_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/hns_back.sv
module hns_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  hns_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    input  logic [7:0]        fail_limit,
    input  logic [7:0]        recover_limit,
    output hns_pkg::div_req_t div_req,
    input  hns_pkg::div_rsp_t div_rsp,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_chosen_node,
    output logic              m_slot_found,
    output logic              m_node_healthy,
    output logic [6:0]        m_live_count
);
    import hns_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FIND   = 11'b00000000010,
        S_UPD    = 11'b00000000100,
        S_WR     = 11'b00000001000,
        S_SCAN   = 11'b00000010000,
        S_DIV1   = 11'b00000100000,
        S_DIV2   = 11'b00001000000,
        S_EVAL   = 11'b00010000000,
        S_RRDIV  = 11'b00100000000,
        S_RRPICK = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(NODES - 1);

    // node table
    logic [ID_W-1:0]   slot_node_reg   [NODES];
    logic              slot_ok_reg     [NODES];
    logic [7:0]        fail_run_reg    [NODES];
    logic [7:0]        success_run_reg [NODES];
    logic [15:0]       avail_reg       [NODES];
    logic [31:0]       req_total_reg   [NODES];
    logic [63:0]       lat_total_reg   [NODES];
    logic [LOAD_W-1:0] cpu_reg         [NODES];
    logic [LOAD_W-1:0] mem_reg         [NODES];
    logic [LOAD_W-1:0] net_reg         [NODES];
    logic [QLEN_W-1:0] qdepth_reg      [NODES];
    logic [31:0]       turn_reg;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  rr_k_reg;
    logic [IDX_W-1:0]  rr_cnt_reg;
    logic              new_reg;
    logic              have_reg;
    logic [63:0]       best_reg;
    logic [63:0]       mean_reg;
    logic [16:0]       lat_reg;
    logic [16:0]       aload_reg;
    logic [31:0]       prod_reg;
    logic [ID_W-1:0]   res_sel_reg;
    logic              res_found_reg;
    logic              res_hl_reg;
    div_req_t          div_req_reg;
    logic              m_valid_reg;
    logic [15:0]       m_sel_reg;
    logic              m_found_reg;
    logic              m_hl_reg;
    logic [6:0]        m_hcnt_reg;

    logic [NODES-1:0]  usable;
    logic [CNT_W-1:0]  hcount;
    logic              match_any;
    logic              free_any;
    logic [IDX_W-1:0]  match_idx;
    logic [IDX_W-1:0]  free_idx;

    logic [31:0]       av_sum;
    logic [16:0]       av_bonus;
    logic [15:0]       rep_av;
    logic [7:0]        rep_fr;
    logic [7:0]        rep_sr;
    logic [31:0]       rep_req;
    logic [64:0]       lat_sum;
    logic [63:0]       rep_lat;
    logic              rep_ok;
    logic [11:0]       ld_sum;
    logic [26:0]       ld_key;
    logic [19:0]       score;
    logic [63:0]       cand;
    logic [64:0]       den_sum;
    logic [63:0]       den;

    always_comb begin
        hcount    = '0;
        match_any = 1'b0;
        free_any  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < NODES; i++) begin
            usable[i] = (slot_node_reg[i] != '0) && slot_ok_reg[i];
            hcount    = hcount + CNT_W'(usable[i]);
        end
        // lowest slot wins
        for (int i = NODES - 1; i >= 0; i--) begin
            if (slot_node_reg[i] == cmd_reg.node) begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (slot_node_reg[i] == '0) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // report update of the addressed slot
    always_comb begin
        av_sum   = prod_reg + AVAIL_ROUND;
        av_bonus = {1'b0, av_sum[31:16]} + AVAIL_BONUS;
        lat_sum  = {1'b0, lat_total_reg[idx_reg]} + 65'(cmd_reg.rtime);
        rep_req  = (req_total_reg[idx_reg] == '1) ? req_total_reg[idx_reg]
                                                  : req_total_reg[idx_reg] + 32'd1;
        if (cmd_reg.success) begin
            rep_fr  = '0;
            rep_sr  = (success_run_reg[idx_reg] == 8'hFF) ? 8'hFF
                                                          : success_run_reg[idx_reg] + 8'd1;
            rep_lat = lat_sum[64] ? '1 : lat_sum[63:0];
            rep_av  = av_bonus[16] ? AVAIL_ONE : av_bonus[15:0];
        end else begin
            rep_sr  = '0;
            rep_fr  = (fail_run_reg[idx_reg] == 8'hFF) ? 8'hFF : fail_run_reg[idx_reg] + 8'd1;
            rep_lat = lat_total_reg[idx_reg];
            rep_av  = av_sum[31:16];
        end
        rep_ok = (rep_fr < fail_limit) && ((rep_sr >= recover_limit) || (rep_fr == '0));
    end

    // selection keys; every method minimizes, adaptive through the inverted score
    always_comb begin
        ld_sum  = 12'(cpu_reg[idx_reg]) + 12'(mem_reg[idx_reg]) + 12'(net_reg[idx_reg]);
        ld_key  = 27'(cpu_reg[idx_reg]) * 27'd4 + 27'(mem_reg[idx_reg]) * 27'd3 +
                  27'(net_reg[idx_reg]) * 27'd2 + {1'b0, qdepth_reg[idx_reg], 10'b0};
        score   = 20'(avail_reg[idx_reg]) * 20'd3 + 20'(lat_reg) * 20'd4 +
                  20'(aload_reg) * 20'd3;
        case (cmd_reg.method)
            MTH_LOAD:  cand = 64'(ld_key);
            MTH_LAT:   cand = mean_reg;
            default:   cand = ~64'(score);
        endcase
        den_sum = {1'b0, div_rsp.quo} + {1'b0, LAT_BIAS};
        den     = den_sum[64] ? '1 : den_sum[63:0];
    end

    assign q_pop          = (state_reg == S_IDLE) && q_valid;
    assign div_req        = div_req_reg;
    assign m_valid        = m_valid_reg;
    assign m_chosen_node  = m_sel_reg;
    assign m_slot_found   = m_found_reg;
    assign m_node_healthy = m_hl_reg;
    assign m_live_count   = m_hcnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            turn_reg          <= '0;
            m_valid_reg       <= 1'b0;
            div_req_reg.start <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                slot_node_reg[i]   <= '0;
                slot_ok_reg[i]     <= 1'b0;
                fail_run_reg[i]    <= '0;
                success_run_reg[i] <= '0;
                avail_reg[i]       <= AVAIL_ONE;
                req_total_reg[i]   <= '0;
                lat_total_reg[i]   <= '0;
                cpu_reg[i]         <= '0;
                mem_reg[i]         <= '0;
                net_reg[i]         <= '0;
                qdepth_reg[i]      <= '0;
            end
        end else begin
            div_req_reg.start <= 1'b0;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg       <= q_cmd;
                        res_sel_reg   <= '0;
                        res_found_reg <= 1'b0;
                        res_hl_reg    <= 1'b0;
                        idx_reg       <= '0;
                        have_reg      <= 1'b0;
                        case (q_cmd.kind)
                            KIND_METRICS, KIND_REPORT: state_reg <= S_FIND;
                            KIND_SELECT: begin
                                if (q_cmd.method == MTH_RR) begin
                                    turn_reg <= turn_reg + 32'd1;
                                    if (hcount == '0) begin
                                        state_reg <= S_OUT;
                                    end else begin
                                        div_req_reg.start    <= 1'b1;
                                        div_req_reg.dividend <= 64'(turn_reg);
                                        div_req_reg.divisor  <= 64'(hcount);
                                        state_reg            <= S_RRDIV;
                                    end
                                end else begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_FIND: begin
                    new_reg <= 1'b0;
                    if (match_any) begin
                        idx_reg       <= match_idx;
                        res_found_reg <= 1'b1;
                        state_reg     <= S_UPD;
                    end else if (cmd_reg.kind == KIND_METRICS && free_any) begin
                        idx_reg       <= free_idx;
                        new_reg       <= 1'b1;
                        res_found_reg <= 1'b1;
                        state_reg     <= S_UPD;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_UPD: begin
                    prod_reg  <= 32'(avail_reg[idx_reg]) * 32'(AVAIL_MUL);
                    state_reg <= S_WR;
                end
                S_WR: begin
                    if (cmd_reg.kind == KIND_METRICS) begin
                        if (new_reg) begin
                            slot_node_reg[idx_reg] <= cmd_reg.node;
                            avail_reg[idx_reg]     <= AVAIL_ONE;
                            slot_ok_reg[idx_reg]   <= 1'b1;
                        end
                        cpu_reg[idx_reg]    <= cmd_reg.cpu;
                        mem_reg[idx_reg]    <= cmd_reg.mem;
                        net_reg[idx_reg]    <= cmd_reg.net;
                        qdepth_reg[idx_reg] <= cmd_reg.qlen;
                        res_hl_reg          <= new_reg || slot_ok_reg[idx_reg];
                    end else begin
                        fail_run_reg[idx_reg]    <= rep_fr;
                        success_run_reg[idx_reg] <= rep_sr;
                        req_total_reg[idx_reg]   <= rep_req;
                        lat_total_reg[idx_reg]   <= rep_lat;
                        avail_reg[idx_reg]       <= rep_av;
                        slot_ok_reg[idx_reg]     <= rep_ok;
                        res_hl_reg               <= rep_ok;
                    end
                    state_reg <= S_OUT;
                end
                S_SCAN: begin
                    aload_reg <= LOAD_ONE - div3({ld_sum, 6'b0});
                    lat_reg   <= LAT_NONE;
                    if (!usable[idx_reg] ||
                        (cmd_reg.method == MTH_LAT && req_total_reg[idx_reg] == '0)) begin
                        // skip this slot
                        if (idx_reg == LAST) begin
                            state_reg <= S_OUT;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else if (cmd_reg.method == MTH_LOAD || req_total_reg[idx_reg] == '0) begin
                        state_reg <= S_EVAL;
                    end else begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= lat_total_reg[idx_reg];
                        div_req_reg.divisor  <= 64'(req_total_reg[idx_reg]);
                        state_reg            <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        mean_reg <= div_rsp.quo;
                        if (cmd_reg.method == MTH_ADAPT) begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= LAT_NUM;
                            div_req_reg.divisor  <= den;
                            state_reg            <= S_DIV2;
                        end else begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        lat_reg   <= div_rsp.quo[16:0];
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!have_reg || cand < best_reg) begin
                        have_reg    <= 1'b1;
                        best_reg    <= cand;
                        res_sel_reg <= slot_node_reg[idx_reg];
                    end
                    if (idx_reg == LAST) begin
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_RRDIV: begin
                    if (div_rsp.done) begin
                        rr_k_reg   <= div_rsp.rem[IDX_W-1:0];
                        rr_cnt_reg <= '0;
                        idx_reg    <= '0;
                        state_reg  <= S_RRPICK;
                    end
                end
                S_RRPICK: begin
                    if (usable[idx_reg]) begin
                        rr_cnt_reg <= rr_cnt_reg + 1'b1;
                        if (rr_cnt_reg == rr_k_reg) begin
                            res_sel_reg <= slot_node_reg[idx_reg];
                            state_reg   <= S_OUT;
                        end
                    end
                    if (idx_reg == LAST) begin
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_sel_reg   <= res_sel_reg;
                        m_found_reg <= res_found_reg;
                        m_hl_reg    <= res_hl_reg;
                        m_hcnt_reg  <= 7'(hcount);
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/health_aware_node_selector.sv
// Flow: metrics and report words pass the find state and, on a slot hit, the update and write
// states to the output register; round robin selects by a divider modulo and one slot pass,
// least load by one scan; latency and adaptive by up to one and two 64-step divisions per slot.
// Throughput: one word in service at a time; a 2-entry queue and an input stage absorb bursts.
// Reset (aresetn low, synchronous): table cleared, all slots free, turn counter zero,
// registers back to default_mode 3, fail_limit 3, recover_limit 5, no result pending.
module health_aware_node_selector (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [15:0]        s_node,
    input  logic               s_success,
    input  logic [31:0]        s_response_time,
    input  logic [10:0]        s_cpu_load,
    input  logic [10:0]        s_mem_load,
    input  logic [10:0]        s_net_load,
    input  logic [15:0]        s_queue_len,
    input  logic signed [3:0]  s_mode,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_chosen_node,
    output logic               m_slot_found,
    output logic               m_node_healthy,
    output logic [6:0]         m_live_count
);
    import hns_pkg::*;

    logic [2:0] default_mode_reg;
    logic [7:0] fail_limit_reg;
    logic [7:0] recover_limit_reg;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    cmd_t     push_cmd;
    cmd_t     head_cmd;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // configuration: write only while idle, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_mode_reg  <= CFG_DEFAULT_MODE;
            fail_limit_reg    <= CFG_FAIL_LIMIT;
            recover_limit_reg <= CFG_RECOVER_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEFAULT_MODE:  default_mode_reg  <= cfg_data[2:0];
                REG_FAIL_LIMIT:    fail_limit_reg    <= cfg_data;
                REG_RECOVER_LIMIT: recover_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify each word, resolve the selection method
    hns_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_node          (s_node),
        .s_success       (s_success),
        .s_response_time (s_response_time),
        .s_cpu_load      (s_cpu_load),
        .s_mem_load      (s_mem_load),
        .s_net_load      (s_net_load),
        .s_queue_len     (s_queue_len),
        .s_mode          (s_mode),
        .default_mode    (default_mode_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    // queue: decouple the front from the long-running back end
    hns_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd_in  (push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .cmd_out (head_cmd)
    );

    // shared divider for mean latency, latency score and round-robin modulo
    hns_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // back end: node table, slot scans and the output register
    hns_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_cmd           (head_cmd),
        .q_pop           (q_pop),
        .fail_limit      (fail_limit_reg),
        .recover_limit   (recover_limit_reg),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_node   (m_chosen_node),
        .m_slot_found    (m_slot_found),
        .m_node_healthy  (m_node_healthy),
        .m_live_count    (m_live_count)
    );

    // a table hit never carries a selection
    a_found_no_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_slot_found) |-> (m_chosen_node == '0))
        else $error("result with slot hit carries a selected node");

    // health is only reported for a slot that exists
    a_healthy_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_node_healthy) |-> m_slot_found)
        else $error("healthy flag without slot");

    // healthy count cannot exceed the table, and a healthy node means at least one
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_live_count <= 7'(NODES)) &&
                     (!m_node_healthy || (m_live_count != '0))))
        else $error("healthy count out of range");

endmodule

### bench/tb_health_aware_node_selector.sv
`timescale 1ns / 1ps

module tb_health_aware_node_selector;
    import hns_pkg::*;

    localparam int N_RANDOM = 730;

    // One input word and the result it must produce.
    typedef struct {
        logic [1:0]        op;
        logic [15:0]       node;
        logic              success;
        logic [31:0]       rtime;
        logic [10:0]       cpu;
        logic [10:0]       mem;
        logic [10:0]       net;
        logic [15:0]       qlen;
        logic signed [3:0] mode;
    } word_t;

    typedef struct packed {
        logic [15:0] sel;
        logic        found;
        logic        ok;
        logic [6:0]  healthy;
    } verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [7:0]        cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_op = '0;
    logic [15:0]       s_node = '0;
    logic              s_success = 1'b0;
    logic [31:0]       s_response_time = '0;
    logic [10:0]       s_cpu_load = '0;
    logic [10:0]       s_mem_load = '0;
    logic [10:0]       s_net_load = '0;
    logic [15:0]       s_queue_len = '0;
    logic signed [3:0] s_mode = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [15:0]       m_chosen_node;
    logic              m_slot_found;
    logic              m_node_healthy;
    logic [6:0]        m_live_count;

    health_aware_node_selector u_top (.*);

    always #6 aclk = ~aclk;

    // Shadow of the node table.
    logic [2:0]  sh_default_mode;
    logic [7:0]  sh_fail_limit, sh_recover_limit;
    logic [15:0] sh_id [NODES];
    logic        sh_ok [NODES];
    logic [7:0]  sh_fails [NODES], sh_wins [NODES];
    logic [15:0] sh_avail [NODES];
    logic [31:0] sh_reqs [NODES];
    logic [63:0] sh_lat [NODES];
    logic [10:0] sh_cpu [NODES], sh_mem [NODES], sh_net [NODES];
    logic [15:0] sh_qlen [NODES];
    logic [31:0] sh_turn;

    verdict_t expected_results[$];
    int       errors = 0;
    logic     quiet = 1'b0;   // no idling in the last part of the run
    int       n_fed = 0;

    function automatic int slot_of(logic [15:0] id);
        for (int i = 0; i < NODES; i++) begin
            if (sh_id[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic logic [10:0] cap_load(logic [10:0] v);
        return (v > 11'd1024) ? 11'd1024 : v;
    endfunction

    function automatic logic [15:0] choose_node(logic [2:0] method);
        logic [15:0] best;
        logic [63:0] best_v, v, mean, lat, ld;
        logic        have;
        logic [15:0] list [NODES];
        int          n;
        best = '0;
        best_v = '0;
        have = 1'b0;
        n = 0;
        if (method == MODE_LOAD || method == MODE_LAT || method == MODE_ADAPT) begin
            for (int i = 0; i < NODES; i++) begin
                if (sh_id[i] == 0 || !sh_ok[i]) continue;
                if (method == MODE_LAT && sh_reqs[i] == 0) continue;
                mean = (sh_reqs[i] != 0) ? sh_lat[i] / 64'(sh_reqs[i]) : 64'd0;
                if (method == MODE_LOAD) begin
                    v = 64'(sh_cpu[i]) * 4 + 64'(sh_mem[i]) * 3 + 64'(sh_net[i]) * 2
                        + 64'(sh_qlen[i]) * 1024;
                end else if (method == MODE_LAT) begin
                    v = mean;
                end else begin
                    lat = 64'd65536;
                    if (sh_reqs[i] != 0)
                        lat = 64'd65536000000 / ((mean > 64'hFFFF_FFFF_FFF0_BDBF) ?
                              64'hFFFF_FFFF_FFFF_FFFF : mean + 64'd1000000);
                    ld = 64'd65536 - ((64'(sh_cpu[i]) + sh_mem[i] + sh_net[i]) * 64) / 3;
                    v = 3 * 64'(sh_avail[i]) + 4 * lat + 3 * ld;
                end
                if (!have || (method == MODE_ADAPT ? v > best_v : v < best_v)) begin
                    have = 1'b1;
                    best_v = v;
                    best = sh_id[i];
                end
            end
            return best;
        end
        // round robin: the turn counter advances even with no healthy node
        for (int i = 0; i < NODES; i++) begin
            if (sh_id[i] != 0 && sh_ok[i]) begin
                list[n] = sh_id[i];
                n++;
            end
        end
        if (n != 0) best = list[sh_turn % n];
        sh_turn = sh_turn + 1;
        return best;
    endfunction

    // Apply one word to the shadow table and return the result it causes.
    function automatic verdict_t predict_verdict(word_t w);
        verdict_t r;
        int       s;
        logic [31:0] scaled;
        logic [2:0]  method;
        r = '{default: '0};
        if (w.op == OP_METRICS && w.node != 0) begin
            s = slot_of(w.node);
            if (s < 0) begin
                s = slot_of(16'd0);
                if (s >= 0) begin
                    sh_id[s] = w.node;
                    sh_avail[s] = AVAIL_ONE;
                    sh_ok[s] = 1'b1;
                end
            end
            if (s >= 0) begin
                sh_cpu[s] = cap_load(w.cpu);
                sh_mem[s] = cap_load(w.mem);
                sh_net[s] = cap_load(w.net);
                sh_qlen[s] = w.qlen;
                r.found = 1'b1;
                r.ok = sh_ok[s];
            end
        end else if (w.op == OP_REPORT && w.node != 0) begin
            s = slot_of(w.node);
            if (s >= 0) begin
                scaled = 32'((64'(sh_avail[s]) * 62259 + 32768) >> 16);
                if (sh_reqs[s] != 32'hFFFF_FFFF) sh_reqs[s]++;
                if (w.success) begin
                    sh_fails[s] = '0;
                    if (sh_wins[s] != 8'hFF) sh_wins[s]++;
                    sh_lat[s] = (sh_lat[s] > ~64'(w.rtime)) ? '1 : sh_lat[s] + w.rtime;
                    scaled += 3277;
                    sh_avail[s] = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
                end else begin
                    sh_wins[s] = '0;
                    if (sh_fails[s] != 8'hFF) sh_fails[s]++;
                    sh_avail[s] = scaled[15:0];
                end
                sh_ok[s] = sh_fails[s] < sh_fail_limit &&
                           (sh_wins[s] >= sh_recover_limit || sh_fails[s] == 0);
                r.found = 1'b1;
                r.ok = sh_ok[s];
            end
        end else if (w.op == OP_SELECT) begin
            method = w.mode[3] ? sh_default_mode : 3'(w.mode);
            r.sel = choose_node(method);
        end
        for (int i = 0; i < NODES; i++) begin
            if (sh_id[i] != 0 && sh_ok[i]) r.healthy++;
        end
        return r;
    endfunction

    task automatic clear_shadow();
        sh_default_mode = CFG_DEFAULT_MODE;
        sh_fail_limit = CFG_FAIL_LIMIT;
        sh_recover_limit = CFG_RECOVER_LIMIT;
        sh_turn = '0;
        for (int i = 0; i < NODES; i++) begin
            sh_id[i] = '0; sh_ok[i] = 1'b0; sh_fails[i] = '0; sh_wins[i] = '0;
            sh_avail[i] = AVAIL_ONE; sh_reqs[i] = '0; sh_lat[i] = '0;
            sh_cpu[i] = '0; sh_mem[i] = '0; sh_net[i] = '0; sh_qlen[i] = '0;
        end
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DEFAULT_MODE) sh_default_mode = val[2:0];
        else if (idx == REG_FAIL_LIMIT) sh_fail_limit = val;
        else sh_recover_limit = val;
    endtask

    // Hold off until every result is back, then let a select finish.
    task automatic drain();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Offer one word and hold it until accepted; predict at acceptance.
    task automatic send_word(word_t w, logic check_typed, verdict_t typed);
        verdict_t r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= w.op; s_node <= w.node; s_success <= w.success;
        s_response_time <= w.rtime; s_cpu_load <= w.cpu; s_mem_load <= w.mem;
        s_net_load <= w.net; s_queue_len <= w.qlen; s_mode <= w.mode;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = predict_verdict(w);
        if (check_typed && r != typed) begin
            $display("%0t predictor disagrees with table row: exp %p got %p", $time, typed, r);
            errors++;
        end
        expected_results.push_back(r);
        n_fed++;
    endtask

    task automatic idle_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic word_t make_word(logic [1:0] op, logic [15:0] node, logic ok,
                                        logic [31:0] rt, logic [10:0] ld, logic [15:0] q,
                                        logic signed [3:0] mode);
        word_t w;
        w = '{op: op, node: node, success: ok, rtime: rt, cpu: ld, mem: ld, net: ld,
              qlen: q, mode: mode};
        return w;
    endfunction

    // Random word: mostly a small pool of ids so reports and selects hit known nodes.
    function automatic word_t random_word();
        word_t w;
        int    k;
        k = $urandom_range(0, 99);
        w.op = (k < 35) ? OP_METRICS : (k < 70) ? OP_REPORT : (k < 97) ? OP_SELECT : 2'd3;
        w.node = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
        w.success = ($urandom_range(0, 2) != 0);
        w.rtime = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000000);
        w.cpu = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024));
        w.mem = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024));
        w.net = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024));
        w.qlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
        w.mode = 4'($urandom);
        return w;
    endfunction

    // Directed table: extremes, every op and mode, node zero, full table, unknown node.
    typedef struct {
        word_t    w;
        logic     typed;
        verdict_t v;
    } row_t;

    row_t plan[$];

    task automatic add_row(word_t w, logic typed, verdict_t v);
        row_t r;
        r.w = w; r.typed = typed; r.v = v;
        plan.push_back(r);
    endtask

    initial begin : stimulus
        verdict_t none;
        word_t    w;
        none = '{default: '0};
        clear_shadow();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Select on an empty table, node zero, unknown report, unused op.
        add_row(make_word(OP_SELECT, 0, 0, 0, 0, 0, -1), 1, none);
        add_row(make_word(OP_SELECT, 0, 0, 0, 0, 0, 0), 1, none);
        add_row(make_word(OP_METRICS, 0, 1, '1, 11'h7FF, '1, 7), 1, none);
        add_row(make_word(OP_REPORT, 16'hFFFF, 1, '1, 0, 0, 0), 1, none);
        add_row(make_word(2'd3, 16'h0001, 1, '1, '1, '1, -8), 1, none);
        add_row(make_word(OP_METRICS, 16'hFFFF, 0, 0, 11'h7FF, 16'hFFFF, 0), 1,
                '{sel: 0, found: 1, ok: 1, healthy: 1});
        add_row(make_word(OP_METRICS, 16'h0001, 0, 0, 0, 0, 0), 1,
                '{sel: 0, found: 1, ok: 1, healthy: 2});
        add_row(make_word(OP_REPORT, 16'h0001, 0, 0, 0, 0, 0), 1,
                '{sel: 0, found: 1, ok: 0, healthy: 1});
        add_row(make_word(OP_REPORT, 16'hFFFF, 1, 32'hFFFF_FFFF, 0, 0, 0), 0, none);
        add_row(make_word(OP_REPORT, 16'hFFFF, 1, 32'd0, 0, 0, 0), 0, none);
        for (int m = -8; m <= 7; m += 3)
            add_row(make_word(OP_SELECT, 0, 0, 0, 0, 0, 4'(m)), 0, none);
        // Fill the table; its last loop word and one more unknown node then find no slot.
        for (int i = 2; i <= 16; i++)
            add_row(make_word(OP_METRICS, 16'(i * 1000), 0, 0, 11'(i * 64), 16'(i), 0), 0, none);
        add_row(make_word(OP_METRICS, 16'h7777, 0, 0, 0, 0, 0), 1,
                '{sel: 0, found: 0, ok: 0, healthy: 15});
        for (int m = 0; m < 4; m++)
            add_row(make_word(OP_SELECT, 0, 0, 0, 0, 0, 4'(m)), 0, none);

        foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].v);
        idle_input();
        drain();

        // Fresh slate is not possible without reset, so later phases reuse the full table
        // under several register settings.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_DEFAULT_MODE, 8'd0);
                    write_reg(REG_FAIL_LIMIT, 8'd1);
                    write_reg(REG_RECOVER_LIMIT, 8'd1);
                end
                1: begin
                    write_reg(REG_DEFAULT_MODE, 8'd7);
                    write_reg(REG_FAIL_LIMIT, 8'd255);
                    write_reg(REG_RECOVER_LIMIT, 8'd255);
                end
                2: begin
                    write_reg(REG_DEFAULT_MODE, 8'($urandom_range(1, 3)));
                    write_reg(REG_FAIL_LIMIT, 8'($urandom_range(2, 6)));
                    write_reg(REG_RECOVER_LIMIT, 8'($urandom_range(1, 4)));
                end
                3: begin
                    write_reg(REG_DEFAULT_MODE, 8'd2);
                    write_reg(REG_FAIL_LIMIT, 8'd128);
                    write_reg(REG_RECOVER_LIMIT, 8'd2);
                end
                default: begin
                    write_reg(REG_DEFAULT_MODE, 8'd3);
                    write_reg(REG_FAIL_LIMIT, 8'd3);
                    write_reg(REG_RECOVER_LIMIT, 8'd5);
                end
            endcase
            if (phase == 4) quiet = 1'b1;
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                w = random_word();
                send_word(w, 1'b0, none);
            end
            idle_input();
            drain();
        end

        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS health_aware_node_selector");
        end else begin
            $display("FAIL health_aware_node_selector");
        end
        $finish;
    end

    // Receiver: random stall bursts, and one long hold-off to back up the input.
    initial begin : result_sink
        int long_done;
        long_done = 0;
        @(posedge aresetn);
        forever begin
            if (!long_done && n_fed > 40) begin
                long_done = 1;
                m_ready <= 1'b0;
                repeat (1500) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        verdict_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result word: sel %0d found %0b ok %0b healthy %0d",
                         $time, m_chosen_node, m_slot_found, m_node_healthy,
                         m_live_count);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_chosen_node !== e.sel) begin
                    $display("%0t chosen node exp %0d got %0d", $time, e.sel,
                             m_chosen_node);
                    errors++;
                end
                if (m_slot_found !== e.found) begin
                    $display("%0t slot_found exp %0b got %0b", $time, e.found, m_slot_found);
                    errors++;
                end
                if (m_node_healthy !== e.ok) begin
                    $display("%0t node_healthy exp %0b got %0b", $time, e.ok, m_node_healthy);
                    errors++;
                end
                if (m_live_count !== e.healthy) begin
                    $display("%0t live count exp %0d got %0d", $time, e.healthy,
                             m_live_count);
                    errors++;
                end
            end
        end
    end

    // Worst case: ~800 words, each as long as an adaptive select over a full table, plus stalls, several times over.
    initial begin : watchdog
        #(12 * 10000000);
        $display("FAIL health_aware_node_selector");
        $finish;
    end

endmodule

### sim.f
rtl/core/hns_pkg.sv
rtl/core/hns_front.sv
rtl/core/hns_fifo.sv
rtl/core/hns_div.sv
rtl/core/hns_back.sv
rtl/core/health_aware_node_selector.sv
bench/tb_health_aware_node_selector.sv
